>>> src/scps_pkg.sv
// ----------------------------------------------------------------------------
// scps_pkg
// Shared types and constants for the coverage pyramid score block.
// ----------------------------------------------------------------------------
package scps_pkg;
  localparam int unsigned CoordW = 20;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned ScoreW = 25;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeight = 1'b1;
endpackage

>>> src/scps_ram.sv
// ----------------------------------------------------------------------------
// scps_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module scps_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/scps_front.sv
// ----------------------------------------------------------------------------
// scps_front
// Accepts points and computes the finest cell indexes by restoring division.
// ----------------------------------------------------------------------------
module scps_front import scps_pkg::*; #(
  parameter int unsigned Levels    = 6,
  parameter int unsigned FracBits  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CoordW-1:0] x_i,
  input  logic [CoordW-1:0] y_i,
  input  logic [SizeW-1:0]  width_i,
  input  logic [SizeW-1:0]  height_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output logic [Levels-1:0] ix_o,
  output logic [Levels-1:0] iy_o
);
  localparam int unsigned NumW = CoordW - 1 + Levels;
  localparam int unsigned DenW = SizeW + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  typedef enum logic [1:0] {Idle, Divide, Hold} state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic [NumW-1:0]   nx_q, ny_q, qx_q, qy_q;
  logic [DenW:0]     rx_q, ry_q;
  logic [DenW-1:0]   dx_q, dy_q;
  logic [DenW:0]     rx_s, ry_s;
  logic [DenW:0]     tx, ty;
  logic [SizeW-1:0]  w_c, h_c;

  assign w_c = (width_i == '0) ? SizeW'(1) : width_i;
  assign h_c = (height_i == '0) ? SizeW'(1) : height_i;
  assign rx_s = {rx_q[DenW-1:0], nx_q[NumW-1]};
  assign ry_s = {ry_q[DenW-1:0], ny_q[NumW-1]};
  assign tx = rx_s - {1'b0, dx_q};
  assign ty = ry_s - {1'b0, dy_q};

  function automatic logic [Levels-1:0] sat(input logic [NumW-1:0] q);
    sat = (q > NumW'({Levels{1'b1}})) ? {Levels{1'b1}} : q[Levels-1:0];
  endfunction

  assign in_ready_o = (state_q == Idle);
  assign q_valid_o  = (state_q == Hold);
  assign ix_o = sat(qx_q);
  assign iy_o = sat(qy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        Idle: begin
          if (in_valid_i) begin
            state_q <= Divide;
            cnt_q   <= CntW'(NumW);
            nx_q <= x_i[CoordW-1] ? '0 : {x_i[CoordW-2:0], {Levels{1'b0}}};
            ny_q <= y_i[CoordW-1] ? '0 : {y_i[CoordW-2:0], {Levels{1'b0}}};
            dx_q <= {w_c, {FracBits{1'b0}}};
            dy_q <= {h_c, {FracBits{1'b0}}};
            rx_q <= '0;
            ry_q <= '0;
          end
        end
        Divide: begin
          rx_q <= tx[DenW] ? rx_s : tx;
          ry_q <= ty[DenW] ? ry_s : ty;
          qx_q <= {qx_q[NumW-2:0], ~tx[DenW]};
          qy_q <= {qy_q[NumW-2:0], ~ty[DenW]};
          nx_q <= {nx_q[NumW-2:0], 1'b0};
          ny_q <= {ny_q[NumW-2:0], 1'b0};
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_q <= Hold;
          end
        end
        Hold: begin
          if (q_ready_i) begin
            state_q <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Hold && !q_ready_i) |=> (state_q == Hold && $stable(qx_q)))
    else $error("held index changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Divide) |-> (cnt_q != '0))
    else $error("divide count underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == Divide))
    else $error("accept did not start division");
endmodule

>>> src/scps_back.sv
// ----------------------------------------------------------------------------
// scps_back
// Walks the pyramid levels, sets occupancy flags and updates the score.
// Flags are cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module scps_back import scps_pkg::*; #(
  parameter int unsigned Levels = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  logic [Levels-1:0] ix_i,
  input  logic [Levels-1:0] iy_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ScoreW-1:0] score_o
);
  localparam int unsigned Total = ((1 << (2 * (Levels + 1))) - 4) / 3;
  localparam int unsigned AddrW = $clog2(Total);
  localparam int unsigned LvW   = $clog2(Levels + 1);

  typedef enum logic [2:0] {Clear, Idle, Read, Wait, Check, Out} state_e;

  state_e            state_q;
  logic [AddrW-1:0]  addr_q;
  logic [LvW-1:0]    lvl_q;
  logic [Levels-1:0] ix_q, iy_q;
  logic [ScoreW-1:0] score_q;
  logic              we;
  logic              rdata;
  logic [AddrW:0]    pos;
  logic [AddrW:0]    base;
  logic [2*Levels+1:0] cells;

  // level base = 4 + 16 + ... + 4^lvl
  function automatic logic [AddrW:0] level_base(input logic [LvW-1:0] lvl);
    level_base = '0;
    for (int unsigned k = 1; k < Levels; k++) begin
      if (k <= 32'(lvl)) begin
        level_base = level_base | ((AddrW+1)'(1) << (2 * k));
      end
    end
  endfunction

  assign cells = (2*Levels+2)'(1) << (2 * (32'(lvl_q) + 1));
  assign base  = level_base(lvl_q);
  assign pos   = base + (((AddrW+1)'(iy_q) << (32'(lvl_q) + 1)) | (AddrW+1)'(ix_q));
  assign we = (state_q == Clear) || (state_q == Check && !rdata);

  scps_ram #(.Width(1), .Depth(Total)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (state_q != Clear),
    .raddr_i (pos[AddrW-1:0]),
    .rdata_o (rdata)
  );

  assign q_ready_o   = (state_q == Idle);
  assign out_valid_o = (state_q == Out);
  assign score_o     = score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Clear;
      addr_q  <= '0;
      score_q <= '0;
      lvl_q   <= '0;
    end else begin
      case (state_q)
        Clear: begin
          addr_q <= addr_q + AddrW'(1);
          if (addr_q == AddrW'(Total - 1)) begin
            state_q <= Idle;
          end
        end
        Idle: begin
          if (q_valid_i) begin
            ix_q    <= ix_i;
            iy_q    <= iy_i;
            lvl_q   <= LvW'(Levels - 1);
            state_q <= Read;
          end
        end
        Read: begin
          addr_q  <= pos[AddrW-1:0];
          state_q <= Check;
        end
        Check: begin
          if (!rdata) begin
            score_q <= score_q + ScoreW'(cells);
          end
          ix_q <= ix_q >> 1;
          iy_q <= iy_q >> 1;
          if (lvl_q == '0) begin
            state_q <= Out;
          end else begin
            lvl_q   <= lvl_q - LvW'(1);
            state_q <= Wait;
          end
        end
        Wait: state_q <= Read;
        Out: begin
          if (out_ready_i) begin
            state_q <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Out && !out_ready_i) |=> $stable(score_q))
    else $error("score changed while waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Clear) |-> !q_ready_o)
    else $error("accepted during clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Idle) |=> $stable(score_q))
    else $error("score changed while idle");
endmodule

>>> src/spatial_coverage_pyramid_score_top.sv
// ----------------------------------------------------------------------------
// spatial_coverage_pyramid_score_top
// Coverage score of a growing point set over an occupancy pyramid.
// An accepted item is divided in the front, handed off, and then walked through
// the flag update in the back, one level after another, before the result is valid.
// Throughput is set by the front division while results are taken promptly;
// the back walk of one item overlaps the division of the next item.
// After reset the flag RAM (5460 entries for LEVELS = 6) is swept clear; one
// item may be taken and divided then, results wait. Registers reset to 1024.
// ----------------------------------------------------------------------------
module spatial_coverage_pyramid_score_top import scps_pkg::*; #(
  parameter int unsigned LEVELS          = 6,
  parameter int unsigned COORD_FRAC_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CoordW-1:0]  point_x_i,
  input  logic [CoordW-1:0]  point_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ScoreW-1:0]  coverage_score_o
);
  logic [SizeW-1:0]  width_q, height_q;
  logic              q_valid, q_ready;
  logic [LEVELS-1:0] ix, iy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeW'(1024);
      height_q <= SizeW'(1024);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWidth:  width_q  <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scps_front #(.Levels(LEVELS), .FracBits(COORD_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .x_i(point_x_i), .y_i(point_y_i), .width_i(width_q), .height_i(height_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .ix_o(ix), .iy_o(iy)
  );

  scps_back #(.Levels(LEVELS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready),
    .ix_i(ix), .iy_i(iy), .out_valid_o, .out_ready_i,
    .score_o(coverage_score_o)
  );
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for spatial_coverage_pyramid_score_top. Each item carries one image
// point. A local occupancy pyramid predicts the running coverage score, and
// each result is checked against it in order. The run covers corner points,
// several register settings, random points, random idling on both sides and
// one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import scps_pkg::*;

  localparam int unsigned Levels   = 6;
  localparam int unsigned FracBits = 4;
  localparam int unsigned NumCells = ((1 << (2 * (Levels + 1))) - 4) / 3;
  localparam int unsigned DrainCyc = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgWidth;
  logic [SizeW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [CoordW-1:0]  point_x_i = '0;
  logic [CoordW-1:0]  point_y_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ScoreW-1:0]  coverage_score_o;

  spatial_coverage_pyramid_score_top #(
    .LEVELS(Levels),
    .COORD_FRAC_BITS(FracBits)
  ) i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bit               occupied[NumCells];
  logic [ScoreW-1:0] score_acc;
  logic [SizeW-1:0]  width_reg;
  logic [SizeW-1:0]  height_reg;
  logic [ScoreW-1:0] score_q[$];
  int                errors;
  int                n_sent;
  int                n_checked;
  bit                no_idle;
  int                hold_cycles;

  function automatic int unsigned grid_pos(logic [CoordW-1:0] raw, logic [SizeW-1:0] size);
    longint unsigned v;
    longint unsigned q;
    longint unsigned s;
    v = raw;
    if (raw[CoordW-1] || raw == '0) return 0;
    s = (size == '0) ? 1 : size;
    q = (v << Levels) / (s << FracBits);
    return 32'((q > (1 << Levels) - 1) ? (1 << Levels) - 1 : q);
  endfunction

  function automatic logic [ScoreW-1:0] add_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    int unsigned ix;
    int unsigned iy;
    int unsigned dim;
    int unsigned pos;
    ix = grid_pos(x, width_reg);
    iy = grid_pos(y, height_reg);
    for (int lvl = Levels - 1; lvl >= 0; lvl--) begin
      dim = 1 << (lvl + 1);
      pos = (dim * dim - 4) / 3 + iy * dim + ix;
      if (!occupied[pos]) begin
        occupied[pos] = 1'b1;
        score_acc = score_acc + ScoreW'(dim * dim);
      end
      ix >>= 1;
      iy >>= 1;
    end
    return score_acc;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (score_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, coverage_score_o);
        errors++;
      end else begin
        if (coverage_score_o !== score_q[0]) begin
          $display("%0t: score mismatch, expected %0d, actual %0d", $time, score_q[0],
                   coverage_score_o);
          errors++;
        end
        void'(score_q.pop_front());
        n_checked++;
      end
    end
  end

  // receiver: random ready bursts, long hold-off on request
  int rdy_burst;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else if (no_idle) begin
      out_ready_i <= 1'b1;
    end else if (rdy_burst > 0) begin
      rdy_burst--;
    end else begin
      out_ready_i <= $urandom_range(0, 1);
      rdy_burst = $urandom_range(1, 19);
    end
  end

  task automatic send_point(logic [CoordW-1:0] x, logic [CoordW-1:0] y);
    int gap;
    gap = (no_idle || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 19);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    point_x_i  <= x;
    point_y_i  <= y;
    do @(posedge clk_i); while (!in_ready_o);
    score_q.push_back(add_point(x, y));
    n_sent++;
  endtask

  task automatic drain;
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgWidth) width_reg = data;
    else height_reg = data;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [CoordW-1:0] rand_coord(logic [SizeW-1:0] size);
    int unsigned s;
    s = (size == '0) ? 16 : size * 16;
    case ($urandom_range(0, 9))
      0:       return CoordW'($urandom);
      1:       return CoordW'(-$signed({1'b0, $urandom_range(1, 524288)}));
      2:       return CoordW'(s + $urandom_range(0, 64));
      default: return CoordW'($urandom_range(0, (s > 524287) ? 524287 : s - 1));
    endcase
  endfunction

  task automatic test_corners;
    logic [CoordW-1:0] w16;
    w16 = CoordW'(width_reg * 16);
    send_point('0, '0);
    send_point(20'h80000, 20'h80000);
    send_point(20'h7FFFF, 20'h7FFFF);
    send_point(20'h80000, 20'h7FFFF);
    send_point(20'h7FFFF, 20'hFFFFF);
    send_point(20'h00001, 20'h00001);
    send_point(w16, w16);
    send_point(w16 - 1, w16 - 1);
    send_point(w16 / 2, w16 / 2 - 1);
    send_point(20'h0000F, w16 / 64);
    send_point('0, '0);
    drain();
  endtask

  task automatic test_register_extremes;
    write_reg(CfgWidth, 16'd1);
    write_reg(CfgHeight, 16'hFFFF);
    send_point(20'd15, 20'd15);
    send_point(20'd16, 20'h7FFFF);
    send_point(20'd8, 20'h40000);
    send_point(20'h7FFFF, 20'd1);
    drain();
    write_reg(CfgWidth, 16'd0);
    write_reg(CfgHeight, 16'd0);
    send_point(20'd1, 20'd7);
    send_point(20'd12, 20'd3);
    send_point(20'd16, 20'd16);
    drain();
    write_reg(CfgWidth, 16'hFFFF);
    write_reg(CfgHeight, 16'd1);
    send_point(20'h7FFFF, 20'd9);
    send_point(20'h3FFFF, 20'h80001);
    drain();
  endtask

  task automatic test_random_points(int count);
    for (int i = 0; i < count; i++)
      send_point(rand_coord(width_reg), rand_coord(height_reg));
    drain();
  endtask

  task automatic test_backpressure;
    hold_cycles = 600;
    for (int i = 0; i < 40; i++)
      send_point(rand_coord(width_reg), rand_coord(height_reg));
    drain();
  endtask

  initial begin
    for (int i = 0; i < NumCells; i++) occupied[i] = 1'b0;
    score_acc  = '0;
    width_reg  = 16'd1024;
    height_reg = 16'd1024;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_corners();
    test_register_extremes();
    write_reg(CfgWidth, 16'd640);
    write_reg(CfgHeight, 16'd480);
    test_random_points(400);
    test_backpressure();
    write_reg(CfgWidth, 16'($urandom_range(1, 65535)));
    write_reg(CfgHeight, 16'($urandom_range(1, 4096)));
    test_random_points(400);
    write_reg(CfgWidth, 16'd1024);
    write_reg(CfgHeight, 16'd1024);
    test_random_points(400);
    no_idle = 1'b1;
    write_reg(CfgWidth, 16'($urandom_range(1, 2048)));
    write_reg(CfgHeight, 16'($urandom_range(1, 2048)));
    test_random_points(400);

    $display("Covered %0d points, %0d scores checked, final score %0d.", n_sent, n_checked,
             score_acc);
    $display("Settings: default, 1/65535, zero, 640x480, random; idling, hold-off, none.");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("Timeout with %0d results outstanding", score_q.size());
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> spatial_coverage_pyramid_score_top.f
src/scps_pkg.sv
src/scps_ram.sv
src/scps_front.sv
src/scps_back.sv
src/spatial_coverage_pyramid_score_top.sv
tb/sv/tb_top.sv
